// ===== design/cspt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock stepper pulse train package
// Shared types, register indexes, reset values and the coil pattern table.
// ----------------------------------------------------------------------------
package cspt_pkg;

   // Configuration port
   localparam int CFG_INDEX_W = 3;
   localparam int CFG_DATA_W  = 24;

   typedef enum logic [CFG_INDEX_W-1:0] {
      CSR_STEP_NORMAL    = 3'd0,
      CSR_STEP_FAST      = 3'd1,
      CSR_STEP_VERY_FAST = 3'd2,
      CSR_IDLE_NORMAL    = 3'd3,
      CSR_IDLE_LEVEL_ONE = 3'd4,
      CSR_IDLE_LEVEL_TWO = 3'd5
   } csr_index_type;

   localparam logic [7:0]  STEP_NORMAL_RESET    = 8'd165;
   localparam logic [7:0]  STEP_FAST_RESET      = 8'd200;
   localparam logic [7:0]  STEP_VERY_FAST_RESET = 8'd250;
   localparam logic [23:0] IDLE_NORMAL_RESET    = 24'd232514;
   localparam logic [23:0] IDLE_LEVEL_ONE_RESET = 24'd1235;
   localparam logic [23:0] IDLE_LEVEL_TWO_RESET = 24'd550;

   // Speed levels
   localparam logic [2:0] SPEED_NORMAL = 3'd0;
   localparam logic [2:0] SPEED_ONE    = 3'd1;
   localparam logic [2:0] SPEED_TWO    = 3'd2;
   localparam logic [2:0] SPEED_THREE  = 3'd3;
   localparam logic [2:0] SPEED_FOUR   = 3'd4;

   // Hold time counter, 17 bit signed, and its thresholds
   localparam int HOLD_W = 17;
   localparam logic signed [HOLD_W:0]   HOLD_MAX         = 18'sd65535;
   localparam logic signed [HOLD_W-1:0] HOLD_LEVEL_TWO   = 17'sd1225;
   localparam logic signed [HOLD_W-1:0] HOLD_LEVEL_THREE = 17'sd2300;
   localparam logic signed [HOLD_W-1:0] HOLD_LEVEL_FOUR  = 17'sd3675;

   // Port image masks
   localparam logic [5:0] BUTTON_LAMP  = 6'h20;
   localparam logic [5:0] KEEP_LAMPS   = 6'h30;
   localparam logic [5:0] CLEAR_BUTTON = 6'h1F;

   localparam logic [2:0] LAST_PHASE  = 3'd5;
   localparam logic [2:0] BURST_STEPS = 3'd6;
   localparam logic [23:0] IDLE_TICK  = 24'd255;
   localparam logic [23:0] IDLE_CUT   = 24'd10;

   // Event queue between front and back
   localparam int QUEUE_DEPTH   = 2;
   localparam int QUEUE_PTR_W   = 1;
   localparam int QUEUE_COUNT_W = 2;

   typedef enum logic {
      EVENT_OVERFLOW = 1'b0,
      EVENT_BUTTON   = 1'b1
   } event_kind_type;

   typedef struct packed {
      event_kind_type kind;
      logic           back_level;
      logic           forward_level;
      logic [7:0]     timer_now;
   } event_type;

   typedef struct packed {
      logic      valid;
      event_type item;
   } queue_head_type;

   // Part of the state that a button edge touches
   typedef struct packed {
      logic signed [HOLD_W-1:0] hold_ticks;
      logic [2:0]               pace;
      logic                     clockwise;
      logic [5:0]               port_image;
      logic [23:0]              idle_remaining;
      logic [7:0]               step_reload;
   } button_state_type;

   function automatic logic [5:0] coil_pattern(input logic [2:0] phase);
      logic [5:0] pattern;
      case (phase)
         3'd0:    pattern = 6'd17;
         3'd1:    pattern = 6'd7;
         3'd2:    pattern = 6'd22;
         3'd3:    pattern = 6'd14;
         3'd4:    pattern = 6'd24;
         3'd5:    pattern = 6'd9;
         default: pattern = 6'd0;
      endcase
      return pattern;
   endfunction

   // One button changed to the given level.
   function automatic button_state_type button_edge(
      input button_state_type st,
      input logic             level,
      input logic             dir_when_pressed,
      input logic [7:0]       now,
      input logic             in_burst,
      input logic [7:0]       step_normal
   );
      button_state_type nx;
      nx = st;
      if (level == 1'b0) begin
         nx.hold_ticks  = $signed({9'd0, now}) - 17'sd255;
         nx.pace        = SPEED_ONE;
         nx.clockwise   = dir_when_pressed;
         nx.port_image  = st.port_image | BUTTON_LAMP;
         if (!in_burst && st.idle_remaining > IDLE_TICK) begin
            nx.idle_remaining = IDLE_CUT;
         end
      end else begin
         nx.port_image  = st.port_image & CLEAR_BUTTON;
         nx.pace        = SPEED_NORMAL;
         nx.clockwise   = 1'b1;
         nx.step_reload = step_normal;
      end
      return nx;
   endfunction

endpackage

// ===== design/cspt_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock stepper pulse train channels
// Valid/ready channels for event transactions and result transactions.
// ----------------------------------------------------------------------------
interface cspt_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic       back_button_level;
   logic       forward_button_level;
   logic [7:0] timer_now;

   modport source (
      output valid, kind, back_button_level, forward_button_level, timer_now,
      input  ready
   );
   modport sink (
      input  valid, kind, back_button_level, forward_button_level, timer_now,
      output ready
   );
endinterface

interface cspt_rsp_if;
   logic       valid;
   logic       ready;
   logic [5:0] port_pattern;
   logic       heartbeat;
   logic       reload_valid;
   logic [7:0] timer_reload;

   modport source (
      output valid, port_pattern, heartbeat, reload_valid, timer_reload,
      input  ready
   );
   modport sink (
      input  valid, port_pattern, heartbeat, reload_valid, timer_reload,
      output ready
   );
endinterface

// ===== design/clock_stepper_pulse_train_controller_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock stepper pulse train controller
// Burst driver for a clock-hand stepper with button speed-up and heartbeat.
// ----------------------------------------------------------------------------
// Every event transaction (a timer overflow or a button pin change) produces
// exactly one result transaction carrying the port image, the heartbeat level
// and, when needed, a timer reload value. The block sustains one transaction
// per clock cycle while results are taken: an event goes from the input into
// a two-entry queue and is executed by the back end once it is at the head
// of the queue and the output register is free or being taken, and its
// result is then held in the output register until it is taken.
// The combinational state update in the back end sets that rate; the queue
// and the output register let the input keep flowing while a result waits.
// Configuration registers take effect on the next executed event and should
// be written only while no transaction is in flight.
// ----------------------------------------------------------------------------
module clock_stepper_pulse_train_controller_unit (
   input  logic                              clock,
   input  logic                              reset,
   cspt_req_if.sink                          req_chan,
   cspt_rsp_if.source                        rsp_chan,
   input  logic                              csr_write_enable,
   input  logic [cspt_pkg::CFG_INDEX_W-1:0]  csr_index,
   input  logic [cspt_pkg::CFG_DATA_W-1:0]   csr_write_data
);

   logic                      push_valid;
   logic                      push_ready;
   cspt_pkg::event_type       push_item;
   logic                      pop;
   cspt_pkg::queue_head_type  head;

   // The front end classifies each incoming transaction as an overflow or a
   // button event and hands it to the queue.
   cspt_front u_front (
      .req_chan    (req_chan),
      .queue_ready (push_ready),
      .push_valid  (push_valid),
      .push_item   (push_item)
   );

   // The queue decouples input acceptance from result back-pressure.
   cspt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop        (pop),
      .head       (head)
   );

   // The back end owns the configuration and all stepper state, executes the
   // event at the head of the queue and registers the result.
   cspt_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .head             (head),
      .pop              (pop),
      .rsp_chan         (rsp_chan)
   );

endmodule

// ===== design/cspt_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock stepper pulse train front end
// Accepts event transactions, classifies them and pushes them to the queue.
// ----------------------------------------------------------------------------
module cspt_front (
   cspt_req_if.sink             req_chan,
   input  logic                 queue_ready,
   output logic                 push_valid,
   output cspt_pkg::event_type  push_item
);

   assign req_chan.ready = queue_ready;
   assign push_valid     = req_chan.valid;

   always_comb begin
      push_item.kind          = cspt_pkg::event_kind_type'(req_chan.kind);
      push_item.back_level    = req_chan.back_button_level;
      push_item.forward_level = req_chan.forward_button_level;
      // Only button events carry a meaningful timer sample.
      if (push_item.kind == cspt_pkg::EVENT_BUTTON) begin
         push_item.timer_now = req_chan.timer_now;
      end else begin
         push_item.timer_now = 8'd0;
      end
   end

endmodule

// ===== design/cspt_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock stepper pulse train event queue
// Two-entry first-in first-out queue between the front and back ends.
// ----------------------------------------------------------------------------
module cspt_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_valid,
   input  cspt_pkg::event_type        push_item,
   output logic                       push_ready,
   input  logic                       pop,
   output cspt_pkg::queue_head_type   head
);

   cspt_pkg::event_type                  entry_ff [cspt_pkg::QUEUE_DEPTH];
   logic [cspt_pkg::QUEUE_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [cspt_pkg::QUEUE_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [cspt_pkg::QUEUE_COUNT_W-1:0]   count_ff, count_in;
   logic                                 push;
   logic                                 do_pop;

   assign push_ready = (count_ff != cspt_pkg::QUEUE_COUNT_W'(cspt_pkg::QUEUE_DEPTH));
   assign push       = push_valid && push_ready;
   assign do_pop     = pop && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== design/cspt_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock stepper pulse train back end
// Holds the configuration and stepper state, executes one event per cycle
// while the output register is free or being taken, and presents the result there.
// ----------------------------------------------------------------------------
module cspt_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [cspt_pkg::CFG_INDEX_W-1:0]     csr_index,
   input  logic [cspt_pkg::CFG_DATA_W-1:0]      csr_write_data,
   input  cspt_pkg::queue_head_type             head,
   output logic                                 pop,
   cspt_rsp_if.source                           rsp_chan
);

   // Configuration registers
   logic [7:0]  step_normal_ff, step_fast_ff, step_very_fast_ff;
   logic [23:0] idle_normal_ff, idle_one_ff, idle_two_ff;

   // Stepper state
   logic [2:0]                            phase_ff, phase_in;
   logic                                  clockwise_ff, clockwise_in;
   logic                                  in_burst_ff, in_burst_in;
   logic [2:0]                            burst_count_ff, burst_count_in;
   logic [7:0]                            step_reload_ff, step_reload_in;
   logic [23:0]                           idle_ff, idle_in;
   logic [2:0]                            speed_ff, speed_in;
   logic signed [cspt_pkg::HOLD_W-1:0]    hold_ff, hold_in;
   logic                                  last_back_ff, last_back_in;
   logic                                  last_fwd_ff, last_fwd_in;
   logic [5:0]                            port_ff, port_in;
   logic                                  heartbeat_ff, heartbeat_in;

   // Output register
   logic       out_valid_ff;
   logic [5:0] out_port_ff;
   logic       out_heartbeat_ff;
   logic       out_reload_valid_ff, reload_valid_in;
   logic [7:0] out_reload_ff, reload_in;

   assign pop = head.valid && (!out_valid_ff || rsp_chan.ready);

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.port_pattern = out_port_ff;
   assign rsp_chan.heartbeat    = out_heartbeat_ff;
   assign rsp_chan.reload_valid = out_reload_valid_ff;
   assign rsp_chan.timer_reload = out_reload_ff;

   always_comb begin
      cspt_pkg::button_state_type       bst;
      logic signed [cspt_pkg::HOLD_W:0] hold_sum;

      phase_in       = phase_ff;
      clockwise_in   = clockwise_ff;
      in_burst_in    = in_burst_ff;
      burst_count_in = burst_count_ff;
      step_reload_in = step_reload_ff;
      idle_in        = idle_ff;
      speed_in       = speed_ff;
      hold_in        = hold_ff;
      last_back_in   = last_back_ff;
      last_fwd_in    = last_fwd_ff;
      port_in        = port_ff;
      heartbeat_in   = heartbeat_ff;
      reload_valid_in = 1'b0;
      reload_in       = 8'd0;
      hold_sum        = '0;

      bst.hold_ticks     = hold_ff;
      bst.pace           = speed_ff;
      bst.clockwise      = clockwise_ff;
      bst.port_image     = port_ff;
      bst.idle_remaining = idle_ff;
      bst.step_reload    = step_reload_ff;

      if (head.item.kind == cspt_pkg::EVENT_BUTTON) begin
         // Backward button first, then forward; the later one sets direction.
         if (head.item.back_level != last_back_ff) begin
            last_back_in = head.item.back_level;
            bst = cspt_pkg::button_edge(bst, head.item.back_level, 1'b0,
                                        head.item.timer_now, in_burst_ff,
                                        step_normal_ff);
         end
         if (head.item.forward_level != last_fwd_ff) begin
            last_fwd_in = head.item.forward_level;
            bst = cspt_pkg::button_edge(bst, head.item.forward_level, 1'b1,
                                        head.item.timer_now, in_burst_ff,
                                        step_normal_ff);
         end
         hold_in        = bst.hold_ticks;
         speed_in       = bst.pace;
         clockwise_in   = bst.clockwise;
         port_in        = bst.port_image;
         idle_in        = bst.idle_remaining;
         step_reload_in = bst.step_reload;
      end else if (in_burst_ff) begin
         // Next coil pattern; an out-of-range phase leaves the port alone.
         if (phase_ff <= cspt_pkg::LAST_PHASE) begin
            port_in = (port_ff & cspt_pkg::BUTTON_LAMP) |
                      cspt_pkg::coil_pattern(phase_ff);
         end
         if (clockwise_ff) begin
            phase_in = (phase_ff >= cspt_pkg::LAST_PHASE) ? 3'd0 : phase_ff + 3'd1;
         end else begin
            phase_in = (phase_ff == 3'd0) ? cspt_pkg::LAST_PHASE : phase_ff - 3'd1;
         end
         burst_count_in = burst_count_ff + 3'd1;
         if (burst_count_in < cspt_pkg::BURST_STEPS) begin
            reload_valid_in = 1'b1;
            reload_in       = step_reload_ff;
         end else begin
            // Burst done: coils off, load the idle countdown.
            port_in        = port_in & cspt_pkg::KEEP_LAMPS;
            burst_count_in = 3'd0;
            phase_in       = 3'd0;
            in_burst_in    = 1'b0;
            case (speed_ff)
               cspt_pkg::SPEED_ONE:   idle_in = idle_one_ff;
               cspt_pkg::SPEED_TWO:   idle_in = idle_two_ff;
               cspt_pkg::SPEED_THREE: idle_in = 24'd0;
               cspt_pkg::SPEED_FOUR:  idle_in = 24'd0;
               default:               idle_in = idle_normal_ff;
            endcase
         end
      end else begin
         if (speed_ff != cspt_pkg::SPEED_NORMAL) begin
            hold_sum = {hold_ff[cspt_pkg::HOLD_W-1], hold_ff} + 18'sd255;
            if (hold_sum > cspt_pkg::HOLD_MAX) begin
               hold_sum = cspt_pkg::HOLD_MAX;
            end
            hold_in = hold_sum[cspt_pkg::HOLD_W-1:0];
            if (hold_in > cspt_pkg::HOLD_LEVEL_TWO) begin
               if (hold_in > cspt_pkg::HOLD_LEVEL_FOUR) begin
                  step_reload_in = step_very_fast_ff;
                  speed_in       = cspt_pkg::SPEED_FOUR;
               end else if (hold_in > cspt_pkg::HOLD_LEVEL_THREE) begin
                  step_reload_in = step_fast_ff;
                  speed_in       = cspt_pkg::SPEED_THREE;
               end else begin
                  speed_in = cspt_pkg::SPEED_TWO;
               end
            end
         end
         heartbeat_in    = !heartbeat_ff;
         reload_valid_in = 1'b1;
         if (idle_ff > cspt_pkg::IDLE_TICK) begin
            reload_in = 8'd0;
            idle_in   = idle_ff - cspt_pkg::IDLE_TICK;
         end else begin
            reload_in   = 8'd255 - idle_ff[7:0];
            in_burst_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_normal_ff    <= cspt_pkg::STEP_NORMAL_RESET;
         step_fast_ff      <= cspt_pkg::STEP_FAST_RESET;
         step_very_fast_ff <= cspt_pkg::STEP_VERY_FAST_RESET;
         idle_normal_ff    <= cspt_pkg::IDLE_NORMAL_RESET;
         idle_one_ff       <= cspt_pkg::IDLE_LEVEL_ONE_RESET;
         idle_two_ff       <= cspt_pkg::IDLE_LEVEL_TWO_RESET;
      end else if (csr_write_enable) begin
         case (cspt_pkg::csr_index_type'(csr_index))
            cspt_pkg::CSR_STEP_NORMAL:    step_normal_ff    <= csr_write_data[7:0];
            cspt_pkg::CSR_STEP_FAST:      step_fast_ff      <= csr_write_data[7:0];
            cspt_pkg::CSR_STEP_VERY_FAST: step_very_fast_ff <= csr_write_data[7:0];
            cspt_pkg::CSR_IDLE_NORMAL:    idle_normal_ff    <= csr_write_data;
            cspt_pkg::CSR_IDLE_LEVEL_ONE: idle_one_ff       <= csr_write_data;
            cspt_pkg::CSR_IDLE_LEVEL_TWO: idle_two_ff       <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= 3'd0;
         clockwise_ff   <= 1'b1;
         in_burst_ff    <= 1'b1;
         burst_count_ff <= 3'd0;
         step_reload_ff <= cspt_pkg::STEP_NORMAL_RESET;
         idle_ff        <= 24'd0;
         speed_ff       <= cspt_pkg::SPEED_NORMAL;
         hold_ff        <= '0;
         last_back_ff   <= 1'b1;
         last_fwd_ff    <= 1'b1;
         port_ff        <= 6'd0;
         heartbeat_ff   <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (pop) begin
            phase_ff       <= phase_in;
            clockwise_ff   <= clockwise_in;
            in_burst_ff    <= in_burst_in;
            burst_count_ff <= burst_count_in;
            step_reload_ff <= step_reload_in;
            idle_ff        <= idle_in;
            speed_ff       <= speed_in;
            hold_ff        <= hold_in;
            last_back_ff   <= last_back_in;
            last_fwd_ff    <= last_fwd_in;
            port_ff        <= port_in;
            heartbeat_ff   <= heartbeat_in;
            out_valid_ff   <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_port_ff         <= port_in;
         out_heartbeat_ff    <= heartbeat_in;
         out_reload_valid_ff <= reload_valid_in;
         out_reload_ff       <= reload_in;
      end
   end

endmodule

// ===== tb/tb_clock_stepper_pulse_train_controller_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock stepper pulse train controller testbench
// Drives event transactions into the controller, predicts each result with a
// behavioral model of the stepper bursts, idle countdown and button speed-up,
// and checks every result transaction in order against that prediction or the directed table's value.
// ----------------------------------------------------------------------------
module tb_clock_stepper_pulse_train_controller_unit;
   import cspt_pkg::*;

   localparam int RESET_CYCLES    = 9;
   localparam int STALL_PCT       = 10;
   localparam int QUIET_LIMIT     = 2000;
   localparam int SETTLE_CYCLES   = 8;
   localparam int MAX_REPORTS     = 10;
   localparam int NUM_PHASES      = 8;
   localparam int ITEMS_PER_PHASE = 188;
   localparam int LONG_HOLD_TICKS = 320;

   // Phases of the random part whose register setting is fixed in whole or in part.
   localparam int ALL_LOW_PHASE   = 0;
   localparam int ALL_HIGH_PHASE  = 1;
   localparam int LONG_HOLD_PHASE = 2;
   localparam int DEFAULTS_PHASE  = 3;

   // An idle countdown of 72000 lasts well past the point where the hold
   // counter saturates, so one unbroken press reaches the top of the counter.
   localparam logic [23:0] LONG_HOLD_IDLE = 24'd72000;
   // Idle countdowns above this are cut short by a press from the generator.
   localparam logic [23:0] LONG_IDLE = 24'd100000;

   // Percentages of button transactions used for episodes of random traffic.
   localparam int BUSY_CHOICES [5] = '{0, 2, 5, 12, 30};

   localparam logic [5:0] COIL_SEQ [6] = '{6'd17, 6'd7, 6'd22, 6'd14, 6'd24, 6'd9};

   typedef struct packed {
      logic [5:0] pattern;
      logic       beat;
      logic       reload_en;
      logic [7:0] reload;
   } pulse_result_type;

   typedef struct packed {
      event_type        ev;
      logic             typed;
      pulse_result_type want;
   } directed_row_type;

   typedef logic [CFG_DATA_W-1:0] reg_set_type [6];

   // Directed stimulus, run with the reset register values. Rows whose result
   // is obvious carry it; the others are checked against the predictor.
   localparam directed_row_type DIRECTED [25] = '{
      // First burst after reset: forward steps with the normal step reload.
      // Button pin levels on an overflow are ignored.
      '{'{EVENT_OVERFLOW, 1'b1, 1'b1, 8'h00}, 1'b1, '{6'd17, 1'b0, 1'b1, 8'd165}},
      '{'{EVENT_OVERFLOW, 1'b0, 1'b0, 8'hFF}, 1'b1, '{6'd7, 1'b0, 1'b1, 8'd165}},
      '{'{EVENT_OVERFLOW, 1'b1, 1'b0, 8'h55}, 1'b0, '0},
      '{'{EVENT_OVERFLOW, 1'b0, 1'b1, 8'hAA}, 1'b0, '0},
      '{'{EVENT_OVERFLOW, 1'b1, 1'b1, 8'h00}, 1'b0, '0},
      // Sixth step turns the coils off and does not reload the timer.
      '{'{EVENT_OVERFLOW, 1'b1, 1'b1, 8'h00}, 1'b1, '{6'd0, 1'b0, 1'b0, 8'd0}},
      // Long normal idle: heartbeat toggles, reload of zero.
      '{'{EVENT_OVERFLOW, 1'b1, 1'b1, 8'h00}, 1'b1, '{6'd0, 1'b1, 1'b1, 8'd0}},
      // Button transaction without any level change does nothing.
      '{'{EVENT_BUTTON, 1'b1, 1'b1, 8'hFF}, 1'b1, '{6'd0, 1'b1, 1'b0, 8'd0}},
      // Backward press while idle cuts the countdown to ten ticks.
      '{'{EVENT_BUTTON, 1'b0, 1'b1, 8'h00}, 1'b1, '{6'h20, 1'b1, 1'b0, 8'd0}},
      '{'{EVENT_OVERFLOW, 1'b1, 1'b1, 8'h00}, 1'b1, '{6'h20, 1'b0, 1'b1, 8'd245}},
      // Backward burst with the button lamp lit.
      '{'{EVENT_OVERFLOW, 1'b0, 1'b0, 8'h0F}, 1'b0, '0},
      '{'{EVENT_OVERFLOW, 1'b1, 1'b0, 8'hF0}, 1'b0, '0},
      // Both pins change at once: backward release, then forward press wins.
      '{'{EVENT_BUTTON, 1'b1, 1'b0, 8'hFF}, 1'b0, '0},
      '{'{EVENT_OVERFLOW, 1'b1, 1'b1, 8'h00}, 1'b0, '0},
      '{'{EVENT_OVERFLOW, 1'b1, 1'b1, 8'h00}, 1'b0, '0},
      '{'{EVENT_OVERFLOW, 1'b1, 1'b1, 8'h00}, 1'b0, '0},
      '{'{EVENT_OVERFLOW, 1'b1, 1'b1, 8'h00}, 1'b0, '0},
      // Level one idle; the held button climbs to speed level two.
      '{'{EVENT_OVERFLOW, 1'b1, 1'b1, 8'h00}, 1'b0, '0},
      '{'{EVENT_OVERFLOW, 1'b1, 1'b1, 8'h00}, 1'b0, '0},
      '{'{EVENT_OVERFLOW, 1'b1, 1'b1, 8'h00}, 1'b0, '0},
      '{'{EVENT_OVERFLOW, 1'b1, 1'b1, 8'h00}, 1'b0, '0},
      '{'{EVENT_OVERFLOW, 1'b1, 1'b1, 8'h00}, 1'b0, '0},
      // Release, then both pressed together at the top of the timer range.
      '{'{EVENT_BUTTON, 1'b1, 1'b1, 8'h80}, 1'b0, '0},
      '{'{EVENT_BUTTON, 1'b0, 1'b0, 8'hFF}, 1'b0, '0},
      '{'{EVENT_OVERFLOW, 1'b0, 1'b0, 8'h00}, 1'b0, '0}
   };

   logic clock;
   logic reset;
   logic                   csr_write_enable;
   logic [CFG_INDEX_W-1:0] csr_index;
   logic [CFG_DATA_W-1:0]  csr_write_data;

   cspt_req_if req_chan ();
   cspt_rsp_if rsp_chan ();

   clock_stepper_pulse_train_controller_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Predictor state: configuration copy and the controller's own state.
   logic [CFG_DATA_W-1:0] reg_file [6];
   logic [2:0]            coil_step;
   logic                  turn_cw;
   logic                  bursting;
   logic [2:0]            steps_done;
   logic [7:0]            step_time;
   logic [23:0]           idle_left;
   logic [2:0]            speed;
   logic signed [HOLD_W:0] held;
   logic                  prev_back;
   logic                  prev_fwd;
   logic [5:0]            port_img;
   logic                  beat;

   pulse_result_type owed_results [$];
   int          busy_pct = 10;
   int          fail_count = 0;
   logic [31:0] cycle_no = '0;
   int          quiet_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Both sides stall at random, except in a recurring window of cycles in
   // which traffic runs at full rate.
   function automatic logic calm();
      return cycle_no[11:10] == 2'b01;
   endfunction

   function automatic logic stall_now();
      return !calm() && ($urandom_range(0, 99) < STALL_PCT);
   endfunction

   task automatic reset_model();
      reg_file[CSR_STEP_NORMAL]    = {16'd0, STEP_NORMAL_RESET};
      reg_file[CSR_STEP_FAST]      = {16'd0, STEP_FAST_RESET};
      reg_file[CSR_STEP_VERY_FAST] = {16'd0, STEP_VERY_FAST_RESET};
      reg_file[CSR_IDLE_NORMAL]    = IDLE_NORMAL_RESET;
      reg_file[CSR_IDLE_LEVEL_ONE] = IDLE_LEVEL_ONE_RESET;
      reg_file[CSR_IDLE_LEVEL_TWO] = IDLE_LEVEL_TWO_RESET;
      coil_step  = '0;
      turn_cw    = 1'b1;
      bursting   = 1'b1;
      steps_done = '0;
      step_time  = STEP_NORMAL_RESET;
      idle_left  = '0;
      speed      = SPEED_NORMAL;
      held       = '0;
      prev_back  = 1'b1;
      prev_fwd   = 1'b1;
      port_img   = '0;
      beat       = 1'b0;
   endtask

   // A press restarts the hold count from the sampled timer value and picks
   // the direction; a release drops back to normal speed, forward.
   function automatic void button_update(input logic level, input logic dir,
                                         input logic [7:0] now);
      if (level == 1'b0) begin
         held    = $signed({10'd0, now}) - 18'sd255;
         speed   = SPEED_ONE;
         turn_cw = dir;
         port_img = port_img | BUTTON_LAMP;
         if (!bursting && idle_left > IDLE_TICK) begin
            idle_left = IDLE_CUT;
         end
      end else begin
         port_img  = port_img & CLEAR_BUTTON;
         speed     = SPEED_NORMAL;
         turn_cw   = 1'b1;
         step_time = reg_file[CSR_STEP_NORMAL][7:0];
      end
   endfunction

   function automatic pulse_result_type predict_pulse(input event_type ev);
      pulse_result_type r;
      logic [2:0]       nxt;
      r = '0;
      if (ev.kind == EVENT_BUTTON) begin
         // Backward pin first, so a simultaneous forward change wins.
         if (ev.back_level != prev_back) begin
            prev_back = ev.back_level;
            button_update(ev.back_level, 1'b0, ev.timer_now);
         end
         if (ev.forward_level != prev_fwd) begin
            prev_fwd = ev.forward_level;
            button_update(ev.forward_level, 1'b1, ev.timer_now);
         end
      end else if (bursting) begin
         if (coil_step < 3'd6) begin
            port_img = (port_img & BUTTON_LAMP) | COIL_SEQ[coil_step];
         end
         if (turn_cw) begin
            nxt = coil_step + 3'd1;
            coil_step = (nxt > LAST_PHASE) ? 3'd0 : nxt;
         end else begin
            coil_step = (coil_step == 3'd0) ? LAST_PHASE : coil_step - 3'd1;
         end
         steps_done = steps_done + 3'd1;
         if (steps_done < BURST_STEPS) begin
            r.reload_en = 1'b1;
            r.reload    = step_time;
         end else begin
            // Burst over: coils off, timer runs on freely, idle loaded by speed.
            port_img   = port_img & KEEP_LAMPS;
            steps_done = '0;
            coil_step  = '0;
            bursting   = 1'b0;
            case (speed)
               SPEED_ONE:              idle_left = reg_file[CSR_IDLE_LEVEL_ONE];
               SPEED_TWO:              idle_left = reg_file[CSR_IDLE_LEVEL_TWO];
               SPEED_THREE, SPEED_FOUR: idle_left = '0;
               default:                idle_left = reg_file[CSR_IDLE_NORMAL];
            endcase
         end
      end else begin
         if (speed != SPEED_NORMAL) begin
            held = held + 18'sd255;
            if (held > HOLD_MAX) begin
               held = HOLD_MAX;
            end
            if (held > HOLD_LEVEL_TWO) begin
               if (held > HOLD_LEVEL_FOUR) begin
                  step_time = reg_file[CSR_STEP_VERY_FAST][7:0];
                  speed     = SPEED_FOUR;
               end else if (held > HOLD_LEVEL_THREE) begin
                  step_time = reg_file[CSR_STEP_FAST][7:0];
                  speed     = SPEED_THREE;
               end else begin
                  speed = SPEED_TWO;
               end
            end
         end
         beat        = !beat;
         r.reload_en = 1'b1;
         if (idle_left > IDLE_TICK) begin
            r.reload  = 8'd0;
            idle_left = idle_left - IDLE_TICK;
         end else begin
            r.reload = 8'd255 - idle_left[7:0];
            bursting = 1'b1;
         end
      end
      r.pattern = port_img;
      r.beat    = beat;
      return r;
   endfunction

   // Random traffic, mostly overflows so that bursts and idles run their
   // course, with button changes at a rate that varies between episodes.
   function automatic event_type next_event();
      event_type ev;
      int        pick;
      ev.kind          = EVENT_OVERFLOW;
      ev.back_level    = 1'($urandom_range(0, 1));
      ev.forward_level = 1'($urandom_range(0, 1));
      ev.timer_now     = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 149) == 0) begin
         busy_pct = BUSY_CHOICES[$urandom_range(0, 4)];
      end
      if (!bursting && idle_left > LONG_IDLE) begin
         // Cut a very long idle short with a press, releasing first if both
         // buttons are already down.
         ev.kind          = EVENT_BUTTON;
         ev.back_level    = prev_back;
         ev.forward_level = prev_fwd;
         if (prev_fwd) begin
            ev.forward_level = 1'b0;
         end else if (prev_back) begin
            ev.back_level = 1'b0;
         end else begin
            ev.forward_level = 1'b1;
         end
      end else if ($urandom_range(0, 99) < busy_pct) begin
         ev.kind = EVENT_BUTTON;
         pick    = $urandom_range(0, 9);
         if (pick < 6) begin
            ev.back_level    = prev_back;
            ev.forward_level = prev_fwd;
            if (pick < 4) begin
               if ($urandom_range(0, 1)) begin
                  ev.back_level = !prev_back;
               end else begin
                  ev.forward_level = !prev_fwd;
               end
            end else begin
               ev.back_level    = !prev_back;
               ev.forward_level = !prev_fwd;
            end
         end else if (pick >= 8) begin
            ev.back_level    = prev_back;
            ev.forward_level = prev_fwd;
         end
      end
      return ev;
   endfunction

   function automatic reg_set_type pick_settings(input int phase_no);
      reg_set_type s;
      foreach (s[i]) begin
         case ($urandom_range(0, 9))
            0:       s[i] = '0;
            1:       s[i] = '1;
            default: s[i] = (i <= CSR_STEP_VERY_FAST) ? 24'($urandom)
                                                      : 24'($urandom_range(0, 4000));
         endcase
      end
      case (phase_no)
         ALL_LOW_PHASE: begin
            foreach (s[i]) s[i] = '0;
         end
         ALL_HIGH_PHASE: begin
            foreach (s[i]) s[i] = '1;
         end
         LONG_HOLD_PHASE: begin
            s[CSR_IDLE_NORMAL]    = 24'($urandom_range(0, 4000));
            s[CSR_IDLE_LEVEL_ONE] = LONG_HOLD_IDLE;
            s[CSR_IDLE_LEVEL_TWO] = 24'($urandom_range(0, 4000));
         end
         DEFAULTS_PHASE: begin
            s[CSR_STEP_NORMAL]    = {16'd0, STEP_NORMAL_RESET};
            s[CSR_STEP_FAST]      = {16'd0, STEP_FAST_RESET};
            s[CSR_STEP_VERY_FAST] = {16'd0, STEP_VERY_FAST_RESET};
            s[CSR_IDLE_NORMAL]    = IDLE_NORMAL_RESET;
            s[CSR_IDLE_LEVEL_ONE] = IDLE_LEVEL_ONE_RESET;
            s[CSR_IDLE_LEVEL_TWO] = IDLE_LEVEL_TWO_RESET;
         end
         default: ;
      endcase
      return s;
   endfunction

   // Writes all six registers on consecutive edges; the step registers only
   // keep their low byte.
   task automatic write_settings(input reg_set_type vals);
      csr_index_type idx;
      for (int i = 0; i < 6; i++) begin
         idx = csr_index_type'(i);
         csr_write_enable <= 1'b1;
         csr_index        <= idx;
         csr_write_data   <= vals[i];
         reg_file[idx] = (idx <= CSR_STEP_VERY_FAST) ? {16'd0, vals[i][7:0]} : vals[i];
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
   endtask

   // Presents one event transaction, possibly after a random gap, and books
   // its expected result once the controller has taken it.
   task automatic send_event(input event_type ev, input logic typed,
                             input pulse_result_type want);
      pulse_result_type model_r;
      while (stall_now()) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid                <= 1'b1;
      req_chan.kind                 <= ev.kind;
      req_chan.back_button_level    <= ev.back_level;
      req_chan.forward_button_level <= ev.forward_level;
      req_chan.timer_now            <= ev.timer_now;
      @(posedge clock);
      while (!req_chan.ready) begin
         @(posedge clock);
      end
      model_r = predict_pulse(ev);
      owed_results.push_back(typed ? want : model_r);
   endtask

   // Waits until every booked result has come back, then lets the design settle.
   task automatic drain_results();
      while (owed_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
         $display("%s", msg);
      end
   endtask

   // Stimulus: reset, directed table, then phases of random traffic, each
   // opened with a register setting written while nothing is in flight.
   initial begin
      event_type ev;
      reset                         = 1'b1;
      req_chan.valid                = 1'b0;
      req_chan.kind                 = EVENT_OVERFLOW;
      req_chan.back_button_level    = 1'b1;
      req_chan.forward_button_level = 1'b1;
      req_chan.timer_now            = '0;
      csr_write_enable              = 1'b0;
      csr_index                     = CSR_STEP_NORMAL;
      csr_write_data                = '0;
      reset_model();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i]) begin
         send_event(DIRECTED[i].ev, DIRECTED[i].typed, DIRECTED[i].want);
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         // The sender holds off until the controller is empty before the
         // registers change.
         req_chan.valid <= 1'b0;
         drain_results();
         write_settings(pick_settings(p));
         if (p == LONG_HOLD_PHASE) begin
            // One unbroken forward press held through a long level one idle,
            // so the hold count saturates and the speed reaches level four.
            ev = '{EVENT_BUTTON, 1'b1, 1'b1, 8'd0};
            ev.timer_now = 8'($urandom_range(0, 255));
            send_event(ev, 1'b0, '0);
            ev.forward_level = 1'b0;
            ev.timer_now = 8'($urandom_range(0, 255));
            send_event(ev, 1'b0, '0);
            for (int n = 0; n < LONG_HOLD_TICKS; n++) begin
               ev.kind      = EVENT_OVERFLOW;
               ev.timer_now = 8'($urandom_range(0, 255));
               send_event(ev, 1'b0, '0);
            end
            ev = '{EVENT_BUTTON, 1'b1, 1'b1, 8'd0};
            send_event(ev, 1'b0, '0);
         end
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            send_event(next_event(), 1'b0, '0);
         end
      end

      req_chan.valid <= 1'b0;
      drain_results();
      if (owed_results.size() != 0) begin
         note_failure($sformatf("%0d expected results never arrived", owed_results.size()));
      end
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Result side: random back-pressure and an in-order check of every result
   // transaction against the oldest booked expectation.
   initial begin
      pulse_result_type got;
      pulse_result_type want;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            got = '{rsp_chan.port_pattern, rsp_chan.heartbeat,
                    rsp_chan.reload_valid, rsp_chan.timer_reload};
            if (owed_results.size() == 0) begin
               note_failure($sformatf(
                  "unexpected result: pattern=%h beat=%b reload_en=%b reload=%0d",
                  got.pattern, got.beat, got.reload_en, got.reload));
            end else begin
               want = owed_results.pop_front();
               if (got.pattern !== want.pattern || got.beat !== want.beat ||
                   got.reload_en !== want.reload_en || got.reload !== want.reload) begin
                  note_failure($sformatf(
                     {"result mismatch: expected pattern=%h beat=%b reload_en=%b ",
                      "reload=%0d, got pattern=%h beat=%b reload_en=%b reload=%0d"},
                     want.pattern, want.beat, want.reload_en, want.reload,
                     got.pattern, got.beat, got.reload_en, got.reload));
               end
            end
         end
         rsp_chan.ready <= !stall_now();
      end
   end

   // Watchdog: the run ends when no transaction moves on either side for a
   // long stretch of cycles.
   initial begin
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         cycle_no = cycle_no + 1;
         if (reset || (req_chan.valid && req_chan.ready) ||
             (rsp_chan.valid && rsp_chan.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("simulation failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/cspt_pkg.sv
design/cspt_if.sv
design/cspt_front.sv
design/cspt_queue.sv
design/cspt_back.sv
design/clock_stepper_pulse_train_controller_unit.sv
tb/tb_clock_stepper_pulse_train_controller_unit.sv
